// ----- rtl/sea2x_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sea2x_pkg: shared types and blend functions
// Pixel formats, item structs, channel blends and the neighbour vote used by
// the 2x edge-directed scaler.
// ----------------------------------------------------------------------------
package sea2x_pkg;

   localparam int CsrAddrWidth = 3;

   // register index, taken from the word address bit
   typedef enum logic [0:0] {
      CSR_PIXEL_FORMAT = 1'b0
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_RGB565   = 2'd0,
      FMT_ARGB1555 = 2'd1,
      FMT_ARGB8888 = 2'd2
   } fmt_type;

   typedef enum logic [1:0] {
      BLEND_HALF        = 2'd0,
      BLEND_THREE_ONE   = 2'd1,
      BLEND_SIX_ONE_ONE = 2'd2
   } blend_type;

   localparam logic [31:0] AlphaOpaque = 32'hFF00_0000;
   localparam logic [31:0] Mask16      = 32'h0000_FFFF;
   localparam logic [31:0] Mask32      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] above_0;
      logic [31:0] above_1;
      logic [31:0] cur_left;
      logic [31:0] cur_0;
      logic [31:0] cur_1;
      logic [31:0] cur_2;
      logic [31:0] next_left;
      logic [31:0] next_0;
      logic [31:0] next_1;
      logic [31:0] next_2;
      logic [31:0] below_0;
      logic [31:0] below_1;
   } req_item_type;

   typedef struct packed {
      logic [31:0] out_top_left;
      logic [31:0] out_top_right;
      logic [31:0] out_bot_left;
      logic [31:0] out_bot_right;
   } rsp_item_type;

   // register code 3 behaves as 32-bit
   function automatic fmt_type fmt_decode(input logic [1:0] code);
      fmt_type mode;
      unique case (code)
         2'd0:    mode = FMT_RGB565;
         2'd1:    mode = FMT_ARGB1555;
         default: mode = FMT_ARGB8888;
      endcase
      return mode;
   endfunction

   // one channel: weighted sum, truncated
   function automatic logic [7:0] blend_chan(input logic [7:0] ca, input logic [7:0] cb,
                                             input logic [7:0] cc, input blend_type kind);
      logic [10:0] sum;
      logic [10:0] res;
      sum = 11'd0;
      res = 11'd0;
      unique case (kind)
         BLEND_HALF: begin
            sum = {3'd0, ca} + {3'd0, cb};
            res = sum >> 1;
         end
         BLEND_THREE_ONE: begin
            sum = {2'd0, ca, 1'b0} + {3'd0, ca} + {3'd0, cb};
            res = sum >> 2;
         end
         default: begin
            sum = {1'd0, ca, 2'b0} + {2'd0, ca, 1'b0} + {3'd0, cb} + {3'd0, cc};
            res = sum >> 3;
         end
      endcase
      return res[7:0];
   endfunction

   // split a pixel into red, green, blue (zero-extended to 8 bits)
   function automatic logic [23:0] split_rgb(input logic [31:0] p, input fmt_type mode);
      logic [23:0] rgb;
      unique case (mode)
         FMT_RGB565:   rgb = {3'd0, p[15:11], 2'd0, p[10:5], 3'd0, p[4:0]};
         FMT_ARGB1555: rgb = {3'd0, p[14:10], 3'd0, p[9:5], 3'd0, p[4:0]};
         default:      rgb = p[23:0];
      endcase
      return rgb;
   endfunction

   function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c, input blend_type kind,
                                         input fmt_type mode);
      logic [23:0] ra;
      logic [23:0] rb;
      logic [23:0] rc;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  bl;
      logic [31:0] pix;
      ra = split_rgb(a, mode);
      rb = split_rgb(b, mode);
      rc = split_rgb(c, mode);
      r  = blend_chan(ra[23:16], rb[23:16], rc[23:16], kind);
      g  = blend_chan(ra[15:8], rb[15:8], rc[15:8], kind);
      bl = blend_chan(ra[7:0], rb[7:0], rc[7:0], kind);
      unique case (mode)
         FMT_RGB565:   pix = {16'd0, r[4:0], g[5:0], bl[4:0]};
         FMT_ARGB1555: pix = {17'd0, r[4:0], g[4:0], bl[4:0]};
         default:      pix = AlphaOpaque | {8'd0, r, g, bl};
      endcase
      return pix;
   endfunction

   // neighbour test: +1, 0 or -1
   function automatic logic signed [3:0] vote(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
      logic [1:0]        x;
      logic [1:0]        y;
      logic signed [3:0] r;
      x = 2'd0;
      y = 2'd0;
      r = 4'sd0;
      if (a == c) x = x + 2'd1;
      else if (b == c) y = y + 2'd1;
      if (a == d) x = x + 2'd1;
      else if (b == d) y = y + 2'd1;
      if (x <= 2'd1) r = r + 4'sd1;
      if (y <= 2'd1) r = r - 4'sd1;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sea2x_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sea2x_core: edge-directed 2x2 kernel
// Compares the window pixels, picks the diagonal case and copies or blends
// to form the four output pixels. Purely combinational.
// ----------------------------------------------------------------------------
module sea2x_core (
   input  wire logic [1:0]              fmt_code,
   input  wire sea2x_pkg::req_item_type win,
   output sea2x_pkg::rsp_item_type      blk
);
   import sea2x_pkg::*;

   fmt_type           mode;
   logic [31:0]       m;
   logic [31:0]       b1, b2, c4, c5, c6, s2, c1, c2, c3, s1, a1, a2;
   logic [31:0]       tl, tr, bl, br;
   logic [31:0]       half_56;
   logic signed [3:0] score;
   logic              diag_a, diag_b;

   assign mode = fmt_decode(fmt_code);
   assign m    = (mode == FMT_ARGB8888) ? Mask32 : Mask16;

   assign b1 = win.above_0   & m;
   assign b2 = win.above_1   & m;
   assign c4 = win.cur_left  & m;
   assign c5 = win.cur_0     & m;
   assign c6 = win.cur_1     & m;
   assign s2 = win.cur_2     & m;
   assign c1 = win.next_left & m;
   assign c2 = win.next_0    & m;
   assign c3 = win.next_1    & m;
   assign s1 = win.next_2    & m;
   assign a1 = win.below_0   & m;
   assign a2 = win.below_1   & m;

   assign diag_a  = (c2 == c6);
   assign diag_b  = (c5 == c3);
   assign half_56 = blend(c5, c6, 32'd0, BLEND_HALF, mode);
   assign score   = vote(c5, c6, c4, b1) - vote(c6, c5, a2, s1)
                  - vote(c6, c5, c1, a1) + vote(c5, c6, b2, s2);

   always_comb begin
      tl = 32'd0;
      tr = 32'd0;
      bl = 32'd0;
      br = 32'd0;
      priority if (diag_a && !diag_b) begin
         tr = c2;
         bl = c2;
         tl = (c1 == c2 || c6 == b2) ? blend(c2, c5, 32'd0, BLEND_THREE_ONE, mode)
                                     : blend(c6, c5, 32'd0, BLEND_HALF, mode);
         br = (c6 == s2 || c2 == a1) ? blend(c2, c3, 32'd0, BLEND_THREE_ONE, mode)
                                     : blend(c2, c3, 32'd0, BLEND_HALF, mode);
      end else if (diag_b && !diag_a) begin
         tl = c5;
         br = c5;
         tr = (b1 == c5 || c3 == s1) ? blend(c5, c6, 32'd0, BLEND_THREE_ONE, mode)
                                     : blend(c5, c6, 32'd0, BLEND_HALF, mode);
         bl = (c3 == a2 || c4 == c5) ? blend(c5, c2, 32'd0, BLEND_THREE_ONE, mode)
                                     : blend(c3, c2, 32'd0, BLEND_HALF, mode);
      end else if (diag_a && diag_b) begin
         // both diagonals: the vote settles which one wins; a tie keeps both
         priority if (score > 4'sd0) begin
            tr = c2;
            bl = c2;
            tl = half_56;
            br = half_56;
         end else if (score < 4'sd0) begin
            tl = c5;
            br = c5;
            tr = half_56;
            bl = half_56;
         end else begin
            tl = c5;
            br = c5;
            tr = c2;
            bl = c2;
         end
      end else begin
         br = blend(c3, c2, c6, BLEND_SIX_ONE_ONE, mode);
         tl = blend(c5, c6, c2, BLEND_SIX_ONE_ONE, mode);
         bl = blend(c2, c5, c3, BLEND_SIX_ONE_ONE, mode);
         tr = blend(c6, c5, c3, BLEND_SIX_ONE_ONE, mode);
      end
   end

   assign blk.out_top_left  = tl & m;
   assign blk.out_top_right = tr & m;
   assign blk.out_bot_left  = bl & m;
   assign blk.out_bot_right = br & m;

endmodule
`default_nettype wire

// ----- rtl/super_eagle_2x_scaler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// super_eagle_2x_scaler: 2x edge-directed pixel scaler
// Turns one 12-pixel source window into one 2x2 output block per clock.
//
//   port group   direction   handshake
//   req_*        in          start high and busy low takes the item
//   rsp_*        out         rsp_valid high for one cycle, no back-pressure
//   csr (apb)    in/out      write on psel & penable & pwrite, pready tied high
//
// an item can be taken every cycle; its block passes the input register, then the
// result register, with the kernel between them.
// busy stays low: the pipeline never stalls since the receiver cannot.
// reset clears the valid bits and sets pixel_format to RGB565.
// ----------------------------------------------------------------------------
module super_eagle_2x_scaler (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire sea2x_pkg::req_item_type            req_item,
   output logic                                    rsp_valid,
   output sea2x_pkg::rsp_item_type                 rsp_item,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [sea2x_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready
);
   import sea2x_pkg::*;

   logic [1:0]   fmt_ff;
   logic [1:0]   fmt_in;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         csr_write;
   logic         accept;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      fmt_in = fmt_ff;
      if (csr_write && (paddr[2] == CSR_PIXEL_FORMAT)) begin
         fmt_in = pwdata[1:0];
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == CSR_PIXEL_FORMAT) begin
         prdata = {30'd0, fmt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_RGB565;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         in_valid_ff  <= accept;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (in_valid_ff) begin
         out_item_ff <= out_item_in;
      end
   end

   sea2x_core u_core (
      .fmt_code (fmt_ff),
      .win      (in_item_ff),
      .blk      (out_item_in)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule
`default_nettype wire
